/* hdl/multi_channel_soft_timer_bank_assert.svh */
// ============================================================================
// multi_channel_soft_timer_bank assertion macros
// concurrent checks for the timer bank, compiled out when ASSERT_OFF is set
// ============================================================================
`ifndef MULTI_CHANNEL_SOFT_TIMER_BANK_ASSERT_SVH
`define MULTI_CHANNEL_SOFT_TIMER_BANK_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define MCSTB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer bank assertion failed");

// next-cycle implication
`define MCSTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer bank assertion failed");

// invariant that holds at every edge
`define MCSTB_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("timer bank assertion failed");

`else

`define MCSTB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MCSTB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define MCSTB_ASSERT_ALWAYS(label, clk, rst_n, expr)

`endif

`endif

/* hdl/mcstb_pkg.sv */
// ============================================================================
// mcstb_pkg
// shared types, codes and defaults of the soft timer bank
// ============================================================================
package mcstb_pkg;

    localparam int CHANNELS_DEF   = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [7:0] PRESCALE_RESET = 8'd50;

    // channel modes
    localparam logic [1:0] MODE_ONE_SHOT = 2'd0;
    localparam logic [1:0] MODE_PERIODIC = 2'd1;
    localparam logic [1:0] MODE_HOLD     = 2'd2;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_CONFIG = 2'd1,
        REQ_ENABLE = 2'd2,
        REQ_READ   = 2'd3
    } t_req_type;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_LOOKUP,
        ST_RESP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic sweep_rd;
        logic lookup_rd;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic tick_hit;
        logic sweep_last;
        logic out_free;
    } t_dp_status;

endpackage

/* hdl/mcstb_ctrl.sv */
// ============================================================================
// mcstb_ctrl
// sequencer: accept, channel sweep, lookup and result hand-off
// ============================================================================
module mcstb_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  mcstb_pkg::t_dp_status  i_status,
    output mcstb_pkg::t_dp_cmd     o_cmd,
    output logic                   o_busy
);

    mcstb_pkg::t_state r_state;
    mcstb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcstb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mcstb_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_status.tick_hit ? mcstb_pkg::ST_SWEEP : mcstb_pkg::ST_LOOKUP;
                end
            end
            mcstb_pkg::ST_SWEEP: begin
                if (i_status.sweep_last) begin
                    n_state = mcstb_pkg::ST_DRAIN;
                end
            end
            mcstb_pkg::ST_DRAIN:  n_state = mcstb_pkg::ST_LOOKUP;
            mcstb_pkg::ST_LOOKUP: n_state = mcstb_pkg::ST_RESP;
            mcstb_pkg::ST_RESP: begin
                if (i_status.out_free) begin
                    n_state = mcstb_pkg::ST_IDLE;
                end
            end
            default: n_state = mcstb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_busy          = 1'b1;
        case (r_state)
            mcstb_pkg::ST_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.accept = i_valid;
            end
            mcstb_pkg::ST_SWEEP:  o_cmd.sweep_rd  = 1'b1;
            mcstb_pkg::ST_LOOKUP: o_cmd.lookup_rd = 1'b1;
            mcstb_pkg::ST_RESP:   o_cmd.finish    = i_status.out_free;
            default:              o_busy          = 1'b1;
        endcase
    end

endmodule

/* hdl/mcstb_dp.sv */
// ============================================================================
// mcstb_dp
// channel store, prescaler, per-channel step logic and result register
// ============================================================================
module mcstb_dp #(
    parameter int CHANNELS   = mcstb_pkg::CHANNELS_DEF,
    parameter int COUNT_BITS = mcstb_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [7:0]            i_cfg_wr_data,
    input  logic [1:0]            i_req_type,
    input  logic [3:0]            i_channel,
    input  logic [15:0]           i_limit,
    input  logic [1:0]            i_mode,
    input  logic                  i_enable,
    input  logic                  i_clear_fired,
    input  mcstb_pkg::t_dp_cmd    i_cmd,
    output mcstb_pkg::t_dp_status o_status,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic [3:0]            o_out_channel,
    output logic [15:0]           o_count,
    output logic                  o_enabled,
    output logic                  o_fired,
    output logic [15:0]           o_fired_mask,
    output logic                  o_stepped
);

    localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ROW_W     = 2 + 2 * COUNT_BITS;
    localparam int MASK_BITS = (CHANNELS < 16) ? CHANNELS : 16;

    // prescaler
    logic [7:0] r_prescale;
    logic [7:0] r_accum;
    logic [8:0] accum_inc;
    logic       accum_hit;

    // latched request
    mcstb_pkg::t_req_type  r_req_type;
    logic [3:0]            r_ch;
    logic [COUNT_BITS-1:0] r_limit;
    logic [1:0]            r_mode;
    logic                  r_en_req;
    logic                  r_clr;
    logic                  r_ch_ok;
    logic                  r_stepped;
    logic [CH_BITS-1:0]    req_idx;

    // per-channel flags
    logic [CHANNELS-1:0] r_enable;
    logic [CHANNELS-1:0] r_fired;
    logic [CHANNELS-1:0] r_row_vld;

    // channel store: {mode, limit, count}
    logic [ROW_W-1:0]   r_mem [CHANNELS];
    logic [ROW_W-1:0]   r_rd_row;
    logic               r_rd_ok;
    logic [CH_BITS-1:0] rd_addr;
    logic               mem_we;
    logic [CH_BITS-1:0] wr_addr;
    logic [ROW_W-1:0]   wr_data;

    logic [ROW_W-1:0]      row;
    logic [COUNT_BITS-1:0] row_cnt;
    logic [COUNT_BITS-1:0] row_lim;
    logic [1:0]            row_mode;

    // sweep
    logic [CH_BITS-1:0]    r_sweep_idx;
    logic                  r_wb_pend;
    logic [CH_BITS-1:0]    r_wb_idx;
    logic                  wb_en;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  wb_hit;
    logic [COUNT_BITS-1:0] wb_cnt;
    logic                  wb_new_en;

    // result
    logic                  r_out_vld;
    logic [CHANNELS-1:0]   clr_vec;
    logic [CHANNELS-1:0]   fired_after;
    logic                  cfg_wr;

    assign accum_inc = {1'b0, r_accum} + 9'd1;
    assign accum_hit = accum_inc >= {1'b0, r_prescale};
    assign req_idx   = CH_BITS'(r_ch);

    assign o_status.tick_hit   = (mcstb_pkg::t_req_type'(i_req_type) == mcstb_pkg::REQ_TICK)
                                 && accum_hit;
    assign o_status.sweep_last = r_sweep_idx == CH_BITS'(CHANNELS - 1);
    assign o_status.out_free   = !r_out_vld || !i_stall;

    // unwritten rows read as zero
    assign row      = r_rd_ok ? r_rd_row : '0;
    assign row_cnt  = row[COUNT_BITS-1:0];
    assign row_lim  = row[2*COUNT_BITS-1:COUNT_BITS];
    assign row_mode = row[ROW_W-1 -: 2];

    // one channel step
    always_comb begin
        wb_en     = r_enable[r_wb_idx];
        cnt_inc   = (row_cnt < row_lim) ? row_cnt + COUNT_BITS'(1) : row_cnt;
        wb_hit    = wb_en && (cnt_inc >= row_lim);
        wb_new_en = wb_en && (!wb_hit || row_mode == mcstb_pkg::MODE_PERIODIC);
        if (wb_en) begin
            if (wb_hit && (row_mode == mcstb_pkg::MODE_ONE_SHOT ||
                           row_mode == mcstb_pkg::MODE_PERIODIC)) begin
                wb_cnt = '0;
            end else begin
                wb_cnt = cnt_inc;
            end
        end else begin
            wb_cnt = (row_mode == mcstb_pkg::MODE_HOLD) ? row_cnt : '0;
        end
    end

    assign cfg_wr  = i_cmd.finish && (r_req_type == mcstb_pkg::REQ_CONFIG) && r_ch_ok;
    assign mem_we  = r_wb_pend || cfg_wr;
    assign wr_addr = r_wb_pend ? r_wb_idx : req_idx;
    assign wr_data = r_wb_pend ? {row_mode, row_lim, wb_cnt} : {r_mode, r_limit, row_cnt};
    assign rd_addr = i_cmd.sweep_rd ? r_sweep_idx : req_idx;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.sweep_rd || i_cmd.lookup_rd) begin
            r_rd_row <= r_mem[rd_addr];
            r_rd_ok  <= r_row_vld[rd_addr];
        end
    end

    assign clr_vec     = ((r_req_type == mcstb_pkg::REQ_READ) && r_clr && r_ch_ok)
                         ? (CHANNELS'(1) << req_idx) : '0;
    assign fired_after = r_fired & ~clr_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale  <= mcstb_pkg::PRESCALE_RESET;
            r_accum     <= '0;
            r_enable    <= '0;
            r_fired     <= '0;
            r_row_vld   <= '0;
            r_sweep_idx <= '0;
            r_wb_pend   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_prescale <= i_cfg_wr_data;
            end
            if (i_cmd.accept &&
                mcstb_pkg::t_req_type'(i_req_type) == mcstb_pkg::REQ_TICK) begin
                r_accum <= accum_hit ? 8'd0 : accum_inc[7:0];
            end
            if (i_cmd.sweep_rd) begin
                r_sweep_idx <= o_status.sweep_last ? '0 : r_sweep_idx + CH_BITS'(1);
            end
            r_wb_pend <= i_cmd.sweep_rd;
            if (mem_we) begin
                r_row_vld[wr_addr] <= 1'b1;
            end
            if (r_wb_pend) begin
                r_enable[r_wb_idx] <= wb_new_en;
                r_fired[r_wb_idx]  <= r_fired[r_wb_idx] | wb_hit;
            end
            if (i_cmd.finish && r_ch_ok) begin
                if (r_req_type == mcstb_pkg::REQ_ENABLE) begin
                    r_enable[req_idx] <= r_en_req;
                end
                if (r_req_type == mcstb_pkg::REQ_READ && r_clr) begin
                    r_fired[req_idx] <= 1'b0;
                end
            end
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_idx <= r_sweep_idx;
        if (i_cmd.accept) begin
            r_req_type <= mcstb_pkg::t_req_type'(i_req_type);
            r_ch       <= i_channel;
            r_limit    <= COUNT_BITS'(i_limit);
            r_mode     <= i_mode;
            r_en_req   <= i_enable;
            r_clr      <= i_clear_fired;
            r_ch_ok    <= int'(i_channel) < CHANNELS;
            r_stepped  <= o_status.tick_hit;
        end
        if (i_cmd.finish) begin
            o_out_channel <= r_ch;
            o_count       <= r_ch_ok ? 16'(row_cnt) : 16'd0;
            o_enabled     <= r_ch_ok && ((r_req_type == mcstb_pkg::REQ_ENABLE) ? r_en_req
                                                                 : r_enable[req_idx]);
            o_fired       <= r_ch_ok && r_fired[req_idx];
            o_fired_mask  <= 16'(fired_after[MASK_BITS-1:0]);
            o_stepped     <= r_stepped;
        end
    end

    assign o_valid = r_out_vld;

endmodule

/* hdl/multi_channel_soft_timer_bank.sv */
// ============================================================================
// multi_channel_soft_timer_bank
// bank of prescaled software timers with configure, enable and read requests
// ============================================================================
//
//  channel   valid     stall     payload
//  -------   -------   -------   ---------------------------------------------
//  request   i_valid   o_stall   i_req_type i_channel i_limit i_mode i_enable
//                                i_clear_fired
//  result    o_valid   i_stall   o_out_channel o_count o_enabled o_fired
//                                o_fired_mask o_stepped
//  config    i_cfg_wr_en (no stall), i_cfg_wr_data = prescale_ticks
//
//  a word that does not step the timers goes from accept through the lookup
//  to the result; a tick word that steps first sweeps every channel, reading one
//  channel row per cycle through the single read port of the channel store
//  one word is in flight at a time; o_stall stays high until its result is
//  loaded into the output register, which holds while i_stall is high
//  reset is synchronous and needs no clearing pass: per-row valid bits make
//  unwritten channels read as zero
//
module multi_channel_soft_timer_bank #(
    parameter int CHANNELS   = mcstb_pkg::CHANNELS_DEF,
    parameter int COUNT_BITS = mcstb_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_channel,
    input  logic [15:0] i_limit,
    input  logic [1:0]  i_mode,
    input  logic        i_enable,
    input  logic        i_clear_fired,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_out_channel,
    output logic [15:0] o_count,
    output logic        o_enabled,
    output logic        o_fired,
    output logic [15:0] o_fired_mask,
    output logic        o_stepped
);

    `include "multi_channel_soft_timer_bank_assert.svh"

    // command and status between sequencer and datapath
    mcstb_pkg::t_dp_cmd    cmd;
    mcstb_pkg::t_dp_status status;

    // sequencer: idle, sweep over channels, drain of the last write-back,
    // lookup of the addressed channel, result hand-off
    mcstb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_stall)
    );

    // datapath: prescaler, channel store, step logic, output register
    mcstb_dp #(
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req_type    (i_req_type),
        .i_channel     (i_channel),
        .i_limit       (i_limit),
        .i_mode        (i_mode),
        .i_enable      (i_enable),
        .i_clear_fired (i_clear_fired),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_channel (o_out_channel),
        .o_count       (o_count),
        .o_enabled     (o_enabled),
        .o_fired       (o_fired),
        .o_fired_mask  (o_fired_mask),
        .o_stepped     (o_stepped)
    );

    // an accepted word keeps the request side stalled until it is done
    `MCSTB_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, cmd.accept, o_stall)
    // a finished word always lands in the output register
    `MCSTB_ASSERT_NEXT(a_finish_out, i_clk, i_rst_n, cmd.finish, o_valid)
    // store port users never overlap
    `MCSTB_ASSERT_ALWAYS(a_cmd_excl, i_clk, i_rst_n,
        $onehot0({cmd.accept, cmd.sweep_rd, cmd.lookup_rd, cmd.finish}))

endmodule
